// ----- rtl/sff_pkg.sv -----
// ---------------------------------------------------------------------------
// sff_pkg: shared types and constants for the sensor frame filter
// Frame limits, field positions, verdict codes and the request structs that
// travel between the byte accumulator, the ID conversion pipe and the top.
// ---------------------------------------------------------------------------
package sff_pkg;

  // Frame length limits; the byte counter saturates one past the maximum
  localparam int MAX_FRAME_BYTES = 44;
  localparam int MIN_FRAME_BYTES = 24;
  localparam int LEN_CAP         = MAX_FRAME_BYTES + 1;
  localparam int CNT_W           = $clog2(LEN_CAP + 1);
  localparam int LEN_W           = 6;

  // Checksum delay line
  localparam int TAIL_DEPTH = 6;
  localparam int SUM_W      = 16;

  // Byte positions inside a frame
  localparam int POS_HDR0     = 0;
  localparam int POS_HDR1     = 1;
  localparam int POS_VER      = 2;
  localparam int POS_ID_HI_LO = 3;
  localparam int POS_ID_HI_HI = 5;
  localparam int POS_ID_TOP   = 6;
  localparam int POS_ID_END   = 10;
  localparam int POS_TYPE     = 15;
  localparam int POS_RELAY    = 17;

  // Byte constants
  localparam logic [7:0] HDR0_BYTE      = 8'h47;
  localparam logic [7:0] HDR1_BYTE      = 8'h4F;
  localparam logic [7:0] ID_TOP_MAX     = 8'h17;
  localparam logic [7:0] VER_MIN        = 8'h33;
  localparam logic [7:0] VER_MAX        = 8'h36;
  localparam logic [7:0] RELAY_VER      = 8'h33;
  localparam int         RELAY_TYPE_BIT = 7;
  localparam logic [7:0] RELAY_LIMIT    = 8'd5;
  localparam int         RELAY_FRAME_LEN = 32;

  // Device ID: 40-bit binary value, converted to BCD four bits per stage
  localparam int ID_W        = 40;
  localparam int ID_CHUNK    = 4;
  localparam int CONV_STAGES = ID_W / ID_CHUNK;
  localparam int BCD_DIGITS  = 13;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam logic [ID_W-1:0] ID_ALL = ID_W'(64'd99999999999);

  // Decimal week and year fields of the ID
  localparam int         WEEK_DIGIT = 4;
  localparam int         YEAR_DIGIT = 8;
  localparam logic [6:0] WEEK_MAX   = 7'd52;
  localparam logic [6:0] YEAR_MIN   = 7'd18;
  localparam logic [6:0] YEAR_MAX   = 7'd30;

  // Reject codes, first failing check wins
  typedef enum logic [2:0] {
    RSN_OK       = 3'd0,
    RSN_SHORT    = 3'd1,
    RSN_LONG     = 3'd2,
    RSN_HEADER   = 3'd3,
    RSN_ID_HIGH  = 3'd4,
    RSN_VERSION  = 3'd5,
    RSN_CHECKSUM = 3'd6
  } reason_t;

  // Input channel request
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_last;
  } in_item_t;

  // Result channel request
  typedef struct packed {
    logic             accepted;
    logic [2:0]       reject_reason;
    logic             id_valid;
    logic             relay_ok;
    logic [LEN_W-1:0] frame_length;
  } out_item_t;

  // Snapshot of the frame state at its last byte
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] stored;
    logic             header_bad;
    logic             id_high_bad;
    logic [7:0]       version;
    logic [7:0]       type_byte;
    logic [7:0]       relay_byte;
    logic [ID_W-1:0]  ident;
  } frame_t;

  // One request in flight through the ID conversion pipe
  typedef struct packed {
    reason_t          reason;
    logic             relay_ok;
    logic [LEN_W-1:0] frame_length;
    logic             id_high_bad;
    logic             id_all;
    logic             id_over;
    logic [BCD_W-1:0] bcd;
    logic [ID_W-1:0]  rest;
  } conv_t;

endpackage

// ----- rtl/sff_accum.sv -----
// ---------------------------------------------------------------------------
// sff_accum: per-byte frame accumulator
// Counts bytes, tracks header, ID and version checks, runs the checksum
// through a six-byte delay line and snapshots everything at the last byte.
// ---------------------------------------------------------------------------
module sff_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sff_pkg::in_item_t in_data,
  output logic              in_stall,
  output logic              frm_valid,
  output sff_pkg::frame_t   frm,
  input  logic              frm_ready
);

  logic [sff_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [sff_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]                tail_r   [sff_pkg::TAIL_DEPTH];
  logic [7:0]                tail_nxt [sff_pkg::TAIL_DEPTH];
  logic                      hdr_bad_r, hdr_bad_nxt;
  logic                      id_bad_r, id_bad_nxt;
  logic [7:0]                ver_r, ver_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [7:0]                relay_r, relay_nxt;
  logic [sff_pkg::ID_W-1:0]  ident_r, ident_nxt;
  logic                      frm_valid_r;
  sff_pkg::frame_t           frm_r, snap;
  logic                      in_acc;
  logic                      capture;
  logic [7:0]                b;

  // Snapshot slot is free or being drained
  assign in_stall = frm_valid_r && !frm_ready;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_data.rx_byte;

  // Next state for one byte; bytes past the cap are not counted or captured
  always_comb begin
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    hdr_bad_nxt = hdr_bad_r;
    id_bad_nxt  = id_bad_r;
    ver_nxt     = ver_r;
    type_nxt    = type_r;
    relay_nxt   = relay_r;
    ident_nxt   = ident_r;
    for (int i = 0; i < sff_pkg::TAIL_DEPTH; i++) begin
      tail_nxt[i] = tail_r[i];
    end
    capture = cnt_r < sff_pkg::CNT_W'(sff_pkg::LEN_CAP);
    if (capture) begin
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_HDR0) && b != sff_pkg::HDR0_BYTE) begin
        hdr_bad_nxt = 1'b1;
      end
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_HDR1) && b != sff_pkg::HDR1_BYTE) begin
        hdr_bad_nxt = 1'b1;
      end
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_VER)) begin
        ver_nxt = b;
      end
      if (cnt_r >= sff_pkg::CNT_W'(sff_pkg::POS_ID_HI_LO) &&
          cnt_r <= sff_pkg::CNT_W'(sff_pkg::POS_ID_HI_HI) && b != 8'd0) begin
        id_bad_nxt = 1'b1;
      end
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_ID_TOP) && b > sff_pkg::ID_TOP_MAX) begin
        id_bad_nxt = 1'b1;
      end
      if (cnt_r >= sff_pkg::CNT_W'(sff_pkg::POS_ID_TOP) &&
          cnt_r <= sff_pkg::CNT_W'(sff_pkg::POS_ID_END)) begin
        ident_nxt = {ident_r[sff_pkg::ID_W-9:0], b};
      end
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_TYPE)) begin
        type_nxt = b;
      end
      if (cnt_r == sff_pkg::CNT_W'(sff_pkg::POS_RELAY)) begin
        relay_nxt = b;
      end
      // oldest byte leaves the delay line into the sum
      sum_nxt = sum_r + sff_pkg::SUM_W'(tail_r[sff_pkg::TAIL_DEPTH-1]);
      for (int i = sff_pkg::TAIL_DEPTH - 1; i > 0; i--) begin
        tail_nxt[i] = tail_r[i-1];
      end
      tail_nxt[0] = b;
      cnt_nxt     = cnt_r + 1'b1;
    end

    snap.count       = cnt_nxt;
    snap.sum         = sum_nxt;
    snap.stored      = {tail_nxt[sff_pkg::TAIL_DEPTH-1], tail_nxt[sff_pkg::TAIL_DEPTH-2]};
    snap.header_bad  = hdr_bad_nxt;
    snap.id_high_bad = id_bad_nxt;
    snap.version     = ver_nxt;
    snap.type_byte   = type_nxt;
    snap.relay_byte  = relay_nxt;
    snap.ident       = ident_nxt;
  end

  // Frame state; cleared after every verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      hdr_bad_r <= 1'b0;
      id_bad_r  <= 1'b0;
      ver_r     <= '0;
      type_r    <= '0;
      relay_r   <= '0;
      ident_r   <= '0;
      for (int i = 0; i < sff_pkg::TAIL_DEPTH; i++) begin
        tail_r[i] <= '0;
      end
    end else if (in_acc) begin
      if (in_data.is_last) begin
        cnt_r     <= '0;
        sum_r     <= '0;
        hdr_bad_r <= 1'b0;
        id_bad_r  <= 1'b0;
        ver_r     <= '0;
        type_r    <= '0;
        relay_r   <= '0;
        ident_r   <= '0;
        for (int i = 0; i < sff_pkg::TAIL_DEPTH; i++) begin
          tail_r[i] <= '0;
        end
      end else begin
        cnt_r     <= cnt_nxt;
        sum_r     <= sum_nxt;
        hdr_bad_r <= hdr_bad_nxt;
        id_bad_r  <= id_bad_nxt;
        ver_r     <= ver_nxt;
        type_r    <= type_nxt;
        relay_r   <= relay_nxt;
        ident_r   <= ident_nxt;
        for (int i = 0; i < sff_pkg::TAIL_DEPTH; i++) begin
          tail_r[i] <= tail_nxt[i];
        end
      end
    end
  end

  // Snapshot slot valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
    end else if (in_acc && in_data.is_last) begin
      frm_valid_r <= 1'b1;
    end else if (frm_ready) begin
      frm_valid_r <= 1'b0;
    end
  end

  // Snapshot payload
  always_ff @(posedge clk) begin
    if (in_acc && in_data.is_last) begin
      frm_r <= snap;
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

  // State is back to its cleared value right after a frame ends
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.is_last) |=>
      (cnt_r == '0 && sum_r == '0 && !hdr_bad_r && !id_bad_r && ident_r == '0))
    else $error("frame state not cleared after last byte");

  // Counter never runs past the saturation point
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sff_pkg::CNT_W'(sff_pkg::LEN_CAP))
    else $error("byte counter beyond saturation");

endmodule

// ----- rtl/sff_id_pipe.sv -----
// ---------------------------------------------------------------------------
// sff_id_pipe: verdict and device ID conversion pipeline
// First stage resolves the reject code and relay rule; every stage converts
// four more bits of the 40-bit device ID to BCD (shift-and-add-3).
// ---------------------------------------------------------------------------
module sff_id_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            frm_valid,
  input  sff_pkg::frame_t frm,
  output logic            frm_ready,
  output logic            cv_valid,
  output sff_pkg::conv_t  cv,
  input  logic            cv_ready
);

  sff_pkg::conv_t                  st_r   [1:sff_pkg::CONV_STAGES];
  sff_pkg::conv_t                  st_nxt [1:sff_pkg::CONV_STAGES];
  logic [sff_pkg::CONV_STAGES:1]   v_r;
  logic [sff_pkg::CONV_STAGES-1:0] v_src;
  logic [sff_pkg::CONV_STAGES+1:1] rdy;
  sff_pkg::conv_t                  head;
  sff_pkg::reason_t                rsn;

  // One shift-and-add-3 step: fix digits of five or more, shift in one bit
  function automatic logic [sff_pkg::BCD_W-1:0] dabble_bit(
    input logic [sff_pkg::BCD_W-1:0] bcd,
    input logic                      bin
  );
    logic [sff_pkg::BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < sff_pkg::BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[sff_pkg::BCD_W-2:0], bin};
  endfunction

  // Convert the next ID_CHUNK bits of a request
  function automatic sff_pkg::conv_t dabble_chunk(input sff_pkg::conv_t c);
    sff_pkg::conv_t o;
    o = c;
    for (int j = 0; j < sff_pkg::ID_CHUNK; j++) begin
      o.bcd  = dabble_bit(o.bcd, o.rest[sff_pkg::ID_W-1]);
      o.rest = {o.rest[sff_pkg::ID_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Reject code and relay rule from the frame snapshot
  always_comb begin
    if (frm.count < sff_pkg::CNT_W'(sff_pkg::MIN_FRAME_BYTES)) begin
      rsn = sff_pkg::RSN_SHORT;
    end else if (frm.count > sff_pkg::CNT_W'(sff_pkg::MAX_FRAME_BYTES)) begin
      rsn = sff_pkg::RSN_LONG;
    end else if (frm.header_bad) begin
      rsn = sff_pkg::RSN_HEADER;
    end else if (frm.id_high_bad) begin
      rsn = sff_pkg::RSN_ID_HIGH;
    end else if (frm.version < sff_pkg::VER_MIN || frm.version > sff_pkg::VER_MAX) begin
      rsn = sff_pkg::RSN_VERSION;
    end else if (frm.sum != frm.stored) begin
      rsn = sff_pkg::RSN_CHECKSUM;
    end else begin
      rsn = sff_pkg::RSN_OK;
    end

    head.reason       = rsn;
    head.relay_ok     = !(frm.version == sff_pkg::RELAY_VER &&
                          frm.count == sff_pkg::CNT_W'(sff_pkg::RELAY_FRAME_LEN) &&
                          frm.type_byte[sff_pkg::RELAY_TYPE_BIT] &&
                          frm.relay_byte >= sff_pkg::RELAY_LIMIT);
    head.frame_length = sff_pkg::LEN_W'(frm.count);
    head.id_high_bad  = frm.id_high_bad;
    head.id_all       = frm.ident == sff_pkg::ID_ALL;
    head.id_over      = frm.ident > sff_pkg::ID_ALL;
    head.bcd          = '0;
    head.rest         = frm.ident;
  end

  // Stage handshake: a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[sff_pkg::CONV_STAGES+1] = cv_ready;
    for (int k = sff_pkg::CONV_STAGES; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_src[0] = frm_valid;
    for (int k = 1; k < sff_pkg::CONV_STAGES; k++) begin
      v_src[k] = v_r[k];
    end
  end

  // Per-stage conversion step
  always_comb begin
    st_nxt[1] = dabble_chunk(head);
    for (int k = 2; k <= sff_pkg::CONV_STAGES; k++) begin
      st_nxt[k] = dabble_chunk(st_r[k-1]);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= sff_pkg::CONV_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_src[k-1];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int k = 1; k <= sff_pkg::CONV_STAGES; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign frm_ready = rdy[1];
  assign cv_valid  = v_r[sff_pkg::CONV_STAGES];
  assign cv        = st_r[sff_pkg::CONV_STAGES];

endmodule

// ----- rtl/sensor_frame_filter_core.sv -----
// ---------------------------------------------------------------------------
// sensor_frame_filter_core: radio frame checker, one byte per cycle when not stalled
// Accepts frame bytes with a last-byte mark and delivers one verdict per
// frame: reject code, device ID week/year rule, relay rule and length.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low, frames may follow back to back.
// Path: after the last byte is taken, the verdict passes the snapshot register,
//   ten 4-bit stages of ID-to-BCD conversion and the output register.
// The ID conversion pipe sets the latency; stalls on the result side back up
//   through the pipe before they reach the byte input.
// Reset (rst_n low, synchronous) clears the frame state and all valid bits.
// ---------------------------------------------------------------------------
module sensor_frame_filter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sff_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sff_pkg::out_item_t out_data
);

  logic               frm_valid;
  logic               frm_ready;
  sff_pkg::frame_t    frm;
  logic               cv_valid;
  logic               cv_ready;
  sff_pkg::conv_t     cv;
  logic               out_valid_r;
  sff_pkg::out_item_t out_r, out_nxt;
  logic [3:0]         wk_hi, wk_lo, yr_hi, yr_lo;
  logic [6:0]         week, year;
  logic               id_rule;

  sff_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready)
  );

  sff_id_pipe u_id_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready),
    .cv_valid  (cv_valid),
    .cv        (cv),
    .cv_ready  (cv_ready)
  );

  // Week and year decimal fields from the converted ID
  assign wk_lo = cv.bcd[4*sff_pkg::WEEK_DIGIT +: 4];
  assign wk_hi = cv.bcd[4*(sff_pkg::WEEK_DIGIT+1) +: 4];
  assign yr_lo = cv.bcd[4*sff_pkg::YEAR_DIGIT +: 4];
  assign yr_hi = cv.bcd[4*(sff_pkg::YEAR_DIGIT+1) +: 4];
  assign week  = 7'(wk_hi) * 7'd10 + 7'(wk_lo);
  assign year  = 7'(yr_hi) * 7'd10 + 7'(yr_lo);

  // All-nines ID always passes; anything above it fails
  assign id_rule = cv.id_all ||
                   (!cv.id_over && week <= sff_pkg::WEEK_MAX &&
                    year >= sff_pkg::YEAR_MIN && year <= sff_pkg::YEAR_MAX);

  always_comb begin
    out_nxt.accepted      = cv.reason == sff_pkg::RSN_OK;
    out_nxt.reject_reason = cv.reason;
    out_nxt.id_valid      = !cv.id_high_bad && id_rule;
    out_nxt.relay_ok      = cv.relay_ok;
    out_nxt.frame_length  = cv.frame_length;
  end

  // Output register
  assign cv_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cv_ready) begin
      out_valid_r <= cv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cv_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A short verdict always carries a length below the minimum
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.reject_reason == sff_pkg::RSN_SHORT) |->
      (out_r.frame_length < sff_pkg::LEN_W'(sff_pkg::MIN_FRAME_BYTES)))
    else $error("short verdict with length at or above minimum");

  // A long verdict always reports the saturated length
  a_long_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.reject_reason == sff_pkg::RSN_LONG) |->
      (out_r.frame_length == sff_pkg::LEN_W'(sff_pkg::LEN_CAP)))
    else $error("long verdict without saturated length");

endmodule

// ----- sim/sensor_frame_filter_core_test.sv -----
// ---------------------------------------------------------------------------
// sensor_frame_filter_core_test: frame verdict regression
// Streams radio frames into the filter one byte per request and predicts each
// verdict in a scoreboard that tracks the frame state byte by byte. Frames
// cover the length limits, bad header, ID high bytes, version and checksum,
// the decimal week/year ID rule and the relay limit. A directed set runs
// first, then random frames under random idling on both sides. At least one
// long result hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module sensor_frame_filter_core_test;

  typedef bit [7:0] byte_q_t[$];

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 720;
  localparam int HOLD_CYCLES  = 300;
  localparam int FILL_FRAMES  = 20;
  localparam int DRAIN_CYCLES = 40;

  // Verdict predictor and store of expected verdicts
  class frame_verdict_board;
    sff_pkg::out_item_t pending_verdicts[$];
    int unsigned        mismatches;

    bit [5:0]  byte_cnt;
    bit [15:0] run_sum;
    bit [7:0]  tail[sff_pkg::TAIL_DEPTH];
    bit        hdr_bad;
    bit        idhi_bad;
    bit [7:0]  ver_byte;
    bit [7:0]  typ_byte;
    bit [7:0]  hop_byte;
    bit [39:0] ident;

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt = '0;
      run_sum  = '0;
      foreach (tail[i]) tail[i] = '0;
      hdr_bad  = 1'b0;
      idhi_bad = 1'b0;
      ver_byte = '0;
      typ_byte = '0;
      hop_byte = '0;
      ident    = '0;
    endfunction

    // Decimal week/year rule on the 40-bit device ID
    function bit ident_rule(longint unsigned id);
      longint unsigned wk, yr;
      if (id == 64'd99999999999) return 1'b1;
      if (id > 64'd99999999999) return 1'b0;
      wk = (id / 64'd10000) % 64'd100;
      yr = (id / 64'd100000000) % 64'd100;
      return wk <= 64'(sff_pkg::WEEK_MAX) && yr >= 64'(sff_pkg::YEAR_MIN) &&
             yr <= 64'(sff_pkg::YEAR_MAX);
    endfunction

    // Update frame state with one accepted byte; queue a verdict on the last
    function void note_byte(sff_pkg::in_item_t req);
      bit [7:0]           b;
      bit [5:0]           pos;
      bit [15:0]          stored;
      sff_pkg::reason_t   why;
      bit                 relay;
      sff_pkg::out_item_t v;
      b = req.rx_byte;
      if (byte_cnt < sff_pkg::LEN_CAP) begin
        pos = byte_cnt;
        if (pos == sff_pkg::POS_HDR0 && b != sff_pkg::HDR0_BYTE) hdr_bad = 1'b1;
        if (pos == sff_pkg::POS_HDR1 && b != sff_pkg::HDR1_BYTE) hdr_bad = 1'b1;
        if (pos == sff_pkg::POS_VER) ver_byte = b;
        if (pos >= sff_pkg::POS_ID_HI_LO && pos <= sff_pkg::POS_ID_HI_HI &&
            b != 8'h00) idhi_bad = 1'b1;
        if (pos == sff_pkg::POS_ID_TOP && b > sff_pkg::ID_TOP_MAX) idhi_bad = 1'b1;
        if (pos >= sff_pkg::POS_ID_TOP && pos <= sff_pkg::POS_ID_END)
          ident = {ident[31:0], b};
        if (pos == sff_pkg::POS_TYPE) typ_byte = b;
        if (pos == sff_pkg::POS_RELAY) hop_byte = b;
        run_sum = run_sum + tail[sff_pkg::TAIL_DEPTH-1];
        for (int i = sff_pkg::TAIL_DEPTH - 1; i > 0; i--) tail[i] = tail[i-1];
        tail[0]  = b;
        byte_cnt = byte_cnt + 1'b1;
      end
      if (!req.is_last) return;

      stored = {tail[sff_pkg::TAIL_DEPTH-1], tail[sff_pkg::TAIL_DEPTH-2]};
      if (byte_cnt < sff_pkg::MIN_FRAME_BYTES)      why = sff_pkg::RSN_SHORT;
      else if (byte_cnt > sff_pkg::MAX_FRAME_BYTES) why = sff_pkg::RSN_LONG;
      else if (hdr_bad)                             why = sff_pkg::RSN_HEADER;
      else if (idhi_bad)                            why = sff_pkg::RSN_ID_HIGH;
      else if (ver_byte < sff_pkg::VER_MIN || ver_byte > sff_pkg::VER_MAX)
        why = sff_pkg::RSN_VERSION;
      else if (run_sum != stored)                   why = sff_pkg::RSN_CHECKSUM;
      else                                          why = sff_pkg::RSN_OK;

      relay = !(ver_byte == sff_pkg::RELAY_VER && byte_cnt == sff_pkg::RELAY_FRAME_LEN &&
                typ_byte[sff_pkg::RELAY_TYPE_BIT] && hop_byte >= sff_pkg::RELAY_LIMIT);

      v.accepted      = (why == sff_pkg::RSN_OK);
      v.reject_reason = why;
      v.id_valid      = !idhi_bad && ident_rule(64'(ident));
      v.relay_ok      = relay;
      v.frame_length  = byte_cnt;
      pending_verdicts.push_back(v);
      clear_frame();
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one delivered verdict against the oldest expectation
    function void check_verdict(sff_pkg::out_item_t got);
      sff_pkg::out_item_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      field_check("accepted", 32'(want.accepted), 32'(got.accepted));
      field_check("reject_reason", 32'(want.reject_reason), 32'(got.reject_reason));
      field_check("id_valid", 32'(want.id_valid), 32'(got.id_valid));
      field_check("relay_ok", 32'(want.relay_ok), 32'(got.relay_ok));
      field_check("frame_length", 32'(want.frame_length), 32'(got.frame_length));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  sff_pkg::in_item_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  sff_pkg::out_item_t out_data;

  frame_verdict_board board = new();
  int unsigned in_idle_pct  = 21;
  int unsigned out_idle_pct = 62;
  int unsigned hold_left    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned cycle_count  = 0;

  sensor_frame_filter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall, or a long counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Verdict monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_verdict(out_data);
  end

  // One byte request, with random idle cycles in front
  task automatic send_byte(bit [7:0] b, bit last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, is_last: last};
    do @(posedge clk); while (in_stall);
    board.note_byte(in_data);
    bytes_sent++;
  endtask

  task automatic send_frame(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Decimal ID with the given year and week digits, the rest random
  function automatic bit [39:0] decimal_id(int yr, int wk);
    longint unsigned id;
    id = 64'($urandom_range(9)) * 64'd10000000000 + 64'(yr) * 64'd100000000 +
         64'($urandom_range(99)) * 64'd1000000 + 64'(wk) * 64'd10000 +
         64'($urandom_range(9999));
    return id[39:0];
  endfunction

  // Header, version and ID in place, everything else random; no checksum yet
  function automatic byte_q_t make_frame(int len, bit [7:0] ver, bit [39:0] id);
    byte_q_t q;
    for (int i = 0; i < len; i++) begin
      if (i == sff_pkg::POS_HDR0)      q.push_back(sff_pkg::HDR0_BYTE);
      else if (i == sff_pkg::POS_HDR1) q.push_back(sff_pkg::HDR1_BYTE);
      else if (i == sff_pkg::POS_VER)  q.push_back(ver);
      else if (i >= sff_pkg::POS_ID_HI_LO && i <= sff_pkg::POS_ID_HI_HI)
        q.push_back(8'h00);
      else if (i >= sff_pkg::POS_ID_TOP && i <= sff_pkg::POS_ID_END)
        q.push_back(id[8*(sff_pkg::POS_ID_END-i) +: 8]);
      else
        q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  // Sum of the covered bytes, big-endian at length-6 and length-5
  function automatic void seal_checksum(ref byte_q_t q);
    bit [15:0] sum;
    int        n;
    n   = q.size();
    sum = '0;
    if (n < sff_pkg::TAIL_DEPTH) return;
    for (int i = 0; i < n - sff_pkg::TAIL_DEPTH; i++) sum = sum + q[i];
    q[n-sff_pkg::TAIL_DEPTH]   = sum[15:8];
    q[n-sff_pkg::TAIL_DEPTH+1] = sum[7:0];
  endfunction

  function automatic byte_q_t good_frame(int len, bit [7:0] ver, bit [39:0] id);
    byte_q_t q;
    q = make_frame(len, ver, id);
    seal_checksum(q);
    return q;
  endfunction

  // Directed frames: limits, each reject reason, ID rule edges, relay limit
  task automatic directed_frames();
    byte_q_t q;
    send_frame(good_frame(sff_pkg::MIN_FRAME_BYTES, sff_pkg::VER_MIN,
                          decimal_id(int'(sff_pkg::YEAR_MIN), int'(sff_pkg::WEEK_MAX))));
    send_frame(good_frame(sff_pkg::MAX_FRAME_BYTES, sff_pkg::VER_MAX, sff_pkg::ID_ALL));
    send_frame(good_frame(sff_pkg::MIN_FRAME_BYTES - 1, 8'h34,
                          decimal_id(int'(sff_pkg::YEAR_MAX), 0)));
    send_frame(good_frame(sff_pkg::MAX_FRAME_BYTES + 1, 8'h35, decimal_id(20, 10)));
    send_frame(good_frame(60, 8'h35, decimal_id(20, 10)));
    // bad header, first and second byte
    q = make_frame(30, 8'h34, decimal_id(25, 30));
    q[sff_pkg::POS_HDR0] = 8'h00;
    seal_checksum(q);
    send_frame(q);
    q = make_frame(30, 8'h34, decimal_id(25, 30));
    q[sff_pkg::POS_HDR1] = 8'hFF;
    seal_checksum(q);
    send_frame(q);
    // ID high bytes: middle zero byte set, top byte just over its limit
    q = make_frame(28, 8'h34, decimal_id(25, 30));
    q[sff_pkg::POS_ID_HI_LO + 1] = 8'h01;
    seal_checksum(q);
    send_frame(q);
    q = make_frame(28, 8'h34, decimal_id(25, 30));
    q[sff_pkg::POS_ID_TOP] = sff_pkg::ID_TOP_MAX + 8'd1;
    seal_checksum(q);
    send_frame(q);
    // versions just outside the window
    send_frame(good_frame(26, sff_pkg::VER_MIN - 8'd1, decimal_id(22, 5)));
    send_frame(good_frame(26, sff_pkg::VER_MAX + 8'd1, decimal_id(22, 5)));
    // checksum off by one bit
    q = good_frame(40, 8'h35, decimal_id(22, 5));
    q[q.size() - sff_pkg::TAIL_DEPTH + 1] ^= 8'h01;
    send_frame(q);
    // relay limit reached, then one below it
    q = make_frame(sff_pkg::RELAY_FRAME_LEN, sff_pkg::RELAY_VER, decimal_id(19, 1));
    q[sff_pkg::POS_TYPE]  = 8'h80;
    q[sff_pkg::POS_RELAY] = sff_pkg::RELAY_LIMIT;
    seal_checksum(q);
    send_frame(q);
    q = make_frame(sff_pkg::RELAY_FRAME_LEN, sff_pkg::RELAY_VER, decimal_id(19, 1));
    q[sff_pkg::POS_TYPE]  = 8'hFF;
    q[sff_pkg::POS_RELAY] = sff_pkg::RELAY_LIMIT - 8'd1;
    seal_checksum(q);
    send_frame(q);
    // ID rule edges: just above the all-nines value, week 53, years 17 and 31
    send_frame(good_frame(24, 8'h34, 40'h174876E800));
    send_frame(good_frame(24, 8'h34, decimal_id(20, int'(sff_pkg::WEEK_MAX) + 1)));
    send_frame(good_frame(24, 8'h34, decimal_id(int'(sff_pkg::YEAR_MIN) - 1, 3)));
    send_frame(good_frame(24, 8'h34, decimal_id(int'(sff_pkg::YEAR_MAX) + 1, 3)));
    // last-byte mark on consecutive bytes: each ends its own frame
    send_frame('{8'hFF});
    send_frame('{8'h00});
  endtask

  // Mostly well-formed frames with random content, some broken, some noise
  task automatic random_frame();
    byte_q_t   q;
    int        len;
    int        pick;
    bit [7:0]  ver;
    bit [7:0]  v;
    bit [39:0] id;
    int        n;
    len  = int'($urandom_range(sff_pkg::MIN_FRAME_BYTES, sff_pkg::MAX_FRAME_BYTES));
    ver  = 8'($urandom_range(sff_pkg::VER_MIN, sff_pkg::VER_MAX));
    pick = int'($urandom_range(99));
    if (pick < 70)
      id = decimal_id(int'($urandom_range(sff_pkg::YEAR_MIN, sff_pkg::YEAR_MAX)),
                      int'($urandom_range(sff_pkg::WEEK_MAX)));
    else if (pick < 78)
      id = sff_pkg::ID_ALL;
    else
      id = {8'($urandom_range(sff_pkg::ID_TOP_MAX)), 32'($urandom)};
    if ($urandom_range(99) < 20) begin
      len = sff_pkg::RELAY_FRAME_LEN;
      ver = sff_pkg::RELAY_VER;
    end
    q = make_frame(len, ver, id);
    if (len == sff_pkg::RELAY_FRAME_LEN && $urandom_range(1)) begin
      q[sff_pkg::POS_TYPE][sff_pkg::RELAY_TYPE_BIT] = 1'b1;
      q[sff_pkg::POS_RELAY] = 8'($urandom_range(sff_pkg::RELAY_LIMIT + 3));
    end

    pick = int'($urandom_range(99));
    if (pick < 8) begin
      q = q[0:$urandom_range(sff_pkg::MIN_FRAME_BYTES - 2)];
    end else if (pick < 16) begin
      repeat ($urandom_range(sff_pkg::MAX_FRAME_BYTES + 1 - len, 60 - len))
        q.push_back(8'($urandom_range(255)));
    end else if (pick < 22) begin
      q[$urandom_range(sff_pkg::POS_HDR1)] ^= 8'($urandom_range(1, 255));
    end else if (pick < 28) begin
      if ($urandom_range(1))
        q[$urandom_range(sff_pkg::POS_ID_HI_LO, sff_pkg::POS_ID_HI_HI)] =
          8'($urandom_range(1, 255));
      else
        q[sff_pkg::POS_ID_TOP] = 8'($urandom_range(sff_pkg::ID_TOP_MAX + 1, 255));
    end else if (pick < 34) begin
      do v = 8'($urandom_range(255)); while (v >= sff_pkg::VER_MIN && v <= sff_pkg::VER_MAX);
      q[sff_pkg::POS_VER] = v;
    end else if (pick < 42) begin
      q.delete();
      repeat ($urandom_range(1, 60)) q.push_back(8'($urandom_range(255)));
    end
    if (pick >= 42 || pick < 34) seal_checksum(q);
    if (pick >= 42 && pick < 50) begin
      n = q.size();
      q[n - sff_pkg::TAIL_DEPTH + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
    end
    send_frame(q);
  endtask

  // Main sequence
  initial begin
    bit      held;
    byte_q_t q;
    held = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    directed_frames();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent < RANDOM_BYTES / 3) begin
        in_idle_pct  = 21;
        out_idle_pct = 62;
      end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
        in_idle_pct  = 62;
        out_idle_pct = 21;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
        // one long hold-off on results while short frames keep coming
        if (!held) begin
          hold_left = HOLD_CYCLES;
          held      = 1'b1;
          repeat (FILL_FRAMES) begin
            q.delete();
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(255)));
            send_frame(q);
          end
        end
      end
      random_frame();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
